[hw/rtl/htdp_pkg.sv]
// Package for the handle table: item types, operation and status codes,
// storage geometry. No dependencies.
package htdp_pkg;

    localparam int HANDLE_W = 8;
    localparam int DEPTH    = 256;
    localparam int PTR_W    = 9;
    localparam int REC_W    = 64;
    localparam int ATTR_W   = 16;

    typedef enum logic [1:0] {
        MODE_CREATE = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_WRITE  = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_BAD_HANDLE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_DATA,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]          mode;
        logic [HANDLE_W-1:0] handle;
        logic [REC_W-1:0]    record_in;
        logic [ATTR_W-1:0]   kind_in;
        logic [ATTR_W-1:0]   layer_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] handle_out;
        logic [REC_W-1:0]    record_out;
        logic [ATTR_W-1:0]   kind_out;
        logic [ATTR_W-1:0]   layer_out;
        logic [PTR_W-1:0]    live_out;
    } t_out_item;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [REC_W-1:0]    rec;
        logic [ATTR_W-1:0]   kind;
        logic [ATTR_W-1:0]   layer;
    } t_dense;

endpackage

[hw/rtl/htdp_in_if.sv]
// Request channel of the handle table: valid, ready and one request beat.
// Depends on htdp_pkg.
interface htdp_in_if;
    logic               valid;
    logic               ready;
    htdp_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/htdp_out_if.sv]
// Response channel of the handle table: valid, ready and one response beat.
// Depends on htdp_pkg.
interface htdp_out_if;
    logic                valid;
    logic                ready;
    htdp_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/handle_table_dense_pack.sv]
// Handle table with densely packed records and a free-handle stack. One request beat
// gives one response beat. Create, write and error cases pass through the LOOK and FIN
// states before the response register is loaded, read and remove through LOOK, DATA and
// FIN, as the registered reads of the handle map and then of the dense record memory
// must return first; a new request is taken the cycle after the previous one has reached
// the response register, which holds it until it is taken.
// Depends on htdp_pkg, htdp_in_if and htdp_out_if.
module handle_table_dense_pack #(
    parameter int CAPACITY = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    htdp_in_if.sink       i_in,
    htdp_out_if.source    o_out
);
    import htdp_pkg::*;

    localparam int              SLOTS   = (CAPACITY < DEPTH) ? CAPACITY : DEPTH;
    localparam logic [PTR_W-1:0] SLOTS_P = PTR_W'(SLOTS);

    logic [HANDLE_W-1:0] r_map_mem   [DEPTH];
    t_dense              r_dense_mem [DEPTH];
    logic [HANDLE_W-1:0] r_free_mem  [DEPTH];

    t_state              r_state, n_state;
    t_in_item            r_req;
    logic                r_bad;
    logic [HANDLE_W-1:0] r_idx, n_idx;
    logic [HANDLE_W-1:0] r_map_q, r_free_q;
    t_dense              r_dense_q;
    logic [PTR_W-1:0]    r_live, n_live;
    logic [PTR_W-1:0]    r_free_top, n_free_top;
    logic [PTR_W-1:0]    r_next_fresh, n_next_fresh;
    logic [DEPTH-1:0]    r_valid, n_valid;
    t_out_item           r_res, n_res;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                in_acc, out_load;
    logic                map_we, dense_we, free_we;
    logic [HANDLE_W-1:0] map_wa, map_wd, map_ra;
    logic [HANDLE_W-1:0] dense_wa, dense_ra;
    t_dense              dense_wd;
    logic [HANDLE_W-1:0] free_wa, free_wd, free_ra;
    logic [HANDLE_W-1:0] new_handle, last_pos;
    logic                bad_now;

    assign in_acc   = i_in.valid && i_in.ready;
    assign bad_now  = ({1'b0, i_in.data.handle} >= SLOTS_P) || !r_valid[i_in.data.handle];
    assign map_ra   = i_in.data.handle;
    assign free_ra  = r_free_top[HANDLE_W-1:0] - 1'b1;
    assign last_pos = r_live[HANDLE_W-1:0] - 1'b1;
    assign new_handle = (r_free_top != '0) ? r_free_q : r_next_fresh[HANDLE_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (!r_bad && (r_req.mode inside {MODE_READ, MODE_REMOVE})) begin
                    n_state = S_DATA;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DATA: n_state = S_FIN;
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready   = (r_state == S_IDLE);
        out_load     = (r_state == S_FIN) && (!r_out_valid || o_out.ready);
        map_we       = 1'b0;
        map_wa       = r_req.handle;
        map_wd       = r_idx;
        dense_we     = 1'b0;
        dense_wa     = r_idx;
        dense_wd     = r_dense_q;
        dense_ra     = r_map_q;
        free_we      = 1'b0;
        free_wa      = r_free_top[HANDLE_W-1:0];
        free_wd      = r_req.handle;
        n_idx        = r_idx;
        n_live       = r_live;
        n_free_top   = r_free_top;
        n_next_fresh = r_next_fresh;
        n_valid      = r_valid;
        n_res        = r_res;
        case (r_state)
            S_LOOK: begin
                n_res            = '0;
                n_res.status     = ST_OK;
                n_res.handle_out = r_req.handle;
                if (r_req.mode == MODE_CREATE) begin
                    if (r_live >= SLOTS_P) begin
                        n_res.status = ST_FULL;
                    end else begin
                        map_we              = 1'b1;
                        map_wa              = new_handle;
                        map_wd              = r_live[HANDLE_W-1:0];
                        n_valid[new_handle] = 1'b1;
                        dense_we            = 1'b1;
                        dense_wa            = r_live[HANDLE_W-1:0];
                        dense_wd            = '{handle: new_handle, rec: r_req.record_in,
                                                kind: r_req.kind_in, layer: r_req.layer_in};
                        n_live              = r_live + 1'b1;
                        if (r_free_top != '0) begin
                            n_free_top = r_free_top - 1'b1;
                        end else begin
                            n_next_fresh = r_next_fresh + 1'b1;
                        end
                        n_res.handle_out = new_handle;
                    end
                end else if (r_bad) begin
                    n_res.status = ST_BAD_HANDLE;
                end else if (r_req.mode == MODE_WRITE) begin
                    dense_we = 1'b1;
                    dense_wa = r_map_q;
                    dense_wd = '{handle: r_req.handle, rec: r_req.record_in,
                                 kind: r_req.kind_in, layer: r_req.layer_in};
                end else begin
                    n_idx    = r_map_q;
                    dense_ra = (r_req.mode == MODE_READ) ? r_map_q : last_pos;
                end
                n_res.live_out = n_live;
            end
            S_DATA: begin
                if (r_req.mode == MODE_READ) begin
                    n_res.record_out = r_dense_q.rec;
                    n_res.kind_out   = r_dense_q.kind;
                    n_res.layer_out  = r_dense_q.layer;
                end else begin
                    dense_we              = (last_pos != r_idx);
                    map_we                = 1'b1;
                    map_wa                = r_dense_q.handle;
                    n_valid[r_req.handle] = 1'b0;
                    free_we               = 1'b1;
                    n_free_top            = r_free_top + 1'b1;
                    n_live                = r_live - 1'b1;
                end
                n_res.live_out = n_live;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_wa] <= map_wd;
        end
        r_map_q <= r_map_mem[map_ra];
    end

    always_ff @(posedge i_clk) begin
        if (dense_we) begin
            r_dense_mem[dense_wa] <= dense_wd;
        end
        r_dense_q <= r_dense_mem[dense_ra];
    end

    always_ff @(posedge i_clk) begin
        if (free_we) begin
            r_free_mem[free_wa] <= free_wd;
        end
        r_free_q <= r_free_mem[free_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_live       <= '0;
            r_free_top   <= '0;
            r_next_fresh <= '0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_live       <= n_live;
            r_free_top   <= n_free_top;
            r_next_fresh <= n_next_fresh;
            r_valid      <= n_valid;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_in.data;
            r_bad <= bad_now;
        end
        r_idx <= n_idx;
        r_res <= n_res;
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef ASSERT_OFF
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= SLOTS_P)
        else $error("live count above capacity");
    a_handle_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_live + r_free_top) == r_next_fresh)
        else $error("live plus free handles differ from handles issued");
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_live))
        else $error("valid handle count differs from live count");
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_LOOK))
        else $error("accepted beat did not start a lookup");
    a_fin_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("response not loaded on finish");
`endif

endmodule
